FILE: design/scm_pkg.sv
package scm_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int COLOR_BITS     = 24;
    localparam int CHAN_BITS      = 8;
    localparam int NUM_CHANS      = 3;
    localparam int FRAC_BITS      = 16;
    localparam int PROD_BITS      = CHAN_BITS + FRAC_BITS + 2;
    localparam int CFG_DATA_BITS  = VALUE_BITS + COLOR_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int COUNT_BITS     = 3;
    localparam int NUM_STOP_REGS  = 6;
    localparam int DIV_STEP_BITS  = 4;
    localparam int DIV_STAGES     = FRAC_BITS / DIV_STEP_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP0      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOPS_USED = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONTINUOUS = 3'd7;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COLOR_BITS-1:0] color;
    } stop_t;

    // Work item carried through the divider stages. rem starts as the offset
    // into the interval and quot collects the blend fraction.
    typedef struct packed {
        logic [COLOR_BITS-1:0] color_a;
        logic [COLOR_BITS-1:0] color_b;
        logic                  is_default;
        logic [VALUE_BITS-1:0] rem;
        logic [VALUE_BITS-1:0] span;
        logic [FRAC_BITS-1:0]  quot;
    } div_t;

    localparam stop_t STOP_RESET [NUM_STOP_REGS] = '{
        40'h0000FFFFB2,
        40'h4000FECC5C,
        40'h8000FD8D3C,
        40'hC000F03B20,
        40'hFFFFBD0026,
        40'h0000000000
    };

    localparam logic [COUNT_BITS-1:0] STOPS_USED_RESET = 3'd5;

endpackage

FILE: design/scm_if.sv
interface scm_sample_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface scm_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_default;

    modport source (output valid, output red, output green, output blue, output is_default,
                    input ready);
    modport sink (input valid, input red, input green, input blue, input is_default,
                  output ready);
endinterface

FILE: design/scm_stop_select.sv
module scm_stop_select
    import scm_pkg::*;
#(
    parameter int MAX_STOPS   = 6,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  stop_t                  stops [MAX_STOPS],
    input  logic [COUNT_BITS-1:0]  stops_used,
    input  logic                   continuous,
    output logic                   out_valid,
    input  logic                   out_ready,
    output div_t                   out_data
);

    localparam int CMP_BITS = (SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
    localparam int IDX_BITS = $clog2(MAX_STOPS);

    logic                   a_valid_reg;
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    logic [MAX_STOPS-1:0]   a_lt_reg;
    logic [MAX_STOPS-1:0]   a_lt_next;
    logic [COUNT_BITS-1:0]  a_count_reg;
    logic [COUNT_BITS-1:0]  a_count_next;
    logic                   a_ready;

    logic                   b_valid_reg;
    div_t                   b_data_reg;
    div_t                   b_data_next;
    logic                   b_ready;

    logic [IDX_BITS-1:0]    last_idx;
    logic [IDX_BITS-1:0]    k_idx;
    logic [IDX_BITS-1:0]    km1_idx;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Stage A: compare the sample against every stop in parallel.
    always_comb
    begin
        a_count_next = (stops_used > COUNT_BITS'(MAX_STOPS)) ? COUNT_BITS'(MAX_STOPS)
                                                               : stops_used;
        for (int i = 0; i < MAX_STOPS; i++)
        begin
            a_lt_next[i] = CMP_BITS'(sample) < CMP_BITS'(stops[i].value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_sample_reg <= sample;
            a_lt_reg     <= a_lt_next;
            a_count_reg  <= a_count_next;
        end
    end

    // Stage B: pick the interval and form the divider operands.
    always_comb
    begin
        last_idx = IDX_BITS'(a_count_reg - COUNT_BITS'(1));
        k_idx    = last_idx;
        for (int i = MAX_STOPS - 2; i >= 1; i--)
        begin
            if (int'(a_count_reg) >= i + 2 && a_lt_reg[i])
            begin
                k_idx = IDX_BITS'(i);
            end
        end
        km1_idx = k_idx - IDX_BITS'(1);

        b_data_next            = '0;
        if (a_count_reg == '0)
        begin
            b_data_next.is_default = 1'b1;
        end
        else if (a_lt_reg[0])
        begin
            b_data_next.color_a = stops[0].color;
            b_data_next.color_b = stops[0].color;
        end
        else if (!a_lt_reg[last_idx])
        begin
            b_data_next.color_a = stops[last_idx].color;
            b_data_next.color_b = stops[last_idx].color;
        end
        else if (continuous)
        begin
            b_data_next.color_a = stops[km1_idx].color;
            b_data_next.color_b = stops[k_idx].color;
            b_data_next.rem     = VALUE_BITS'(CMP_BITS'(a_sample_reg)
                                              - CMP_BITS'(stops[km1_idx].value));
            b_data_next.span    = stops[k_idx].value - stops[km1_idx].value;
        end
        else
        begin
            b_data_next.color_a = stops[km1_idx].color;
            b_data_next.color_b = stops[km1_idx].color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

FILE: design/scm_div_stage.sv
module scm_div_stage
    import scm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic                valid_reg;
    div_t                data_reg;
    div_t                data_next;
    logic [VALUE_BITS:0] trial;

    assign in_ready = !valid_reg || out_ready;

    // Restoring division, a few quotient bits per stage. The remainder is either
    // below the span or zero with a zero span, so each trial fits in one extra bit.
    always_comb
    begin
        data_next = in_data;
        trial     = '0;
        for (int j = 0; j < DIV_STEP_BITS; j++)
        begin
            trial = {data_next.rem, 1'b0};
            if (trial >= {1'b0, data_next.span})
            begin
                data_next.rem  = VALUE_BITS'(trial - {1'b0, data_next.span});
                data_next.quot = {data_next.quot[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                data_next.rem  = trial[VALUE_BITS-1:0];
                data_next.quot = {data_next.quot[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: design/scm_blend.sv
module scm_blend
    import scm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  div_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAN_BITS-1:0] red,
    output logic [CHAN_BITS-1:0] green,
    output logic [CHAN_BITS-1:0] blue,
    output logic                 is_default
);

    logic                        m_valid_reg;
    logic signed [PROD_BITS-1:0] m_prod_reg [NUM_CHANS];
    logic signed [PROD_BITS-1:0] m_prod_next [NUM_CHANS];
    logic [COLOR_BITS-1:0]       m_base_reg;
    logic                        m_default_reg;
    logic                        m_ready;

    logic                        o_valid_reg;
    logic [COLOR_BITS-1:0]       o_color_reg;
    logic [COLOR_BITS-1:0]       o_color_next;
    logic                        o_default_reg;
    logic                        o_ready;

    logic signed [CHAN_BITS:0]   delta;

    assign o_ready  = !o_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || o_ready;
    assign in_ready = m_ready;

    // a*(1-f) + b*f equals a + (b-a)*f, and the floor of the signed product
    // keeps the truncation of the unsigned form.
    always_comb
    begin
        delta = '0;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            delta = $signed({1'b0, in_data.color_b[c*CHAN_BITS +: CHAN_BITS]})
                  - $signed({1'b0, in_data.color_a[c*CHAN_BITS +: CHAN_BITS]});
            m_prod_next[c] = PROD_BITS'(delta) * PROD_BITS'($signed({1'b0, in_data.quot}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_ready)
        begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ready && in_valid)
        begin
            m_prod_reg    <= m_prod_next;
            m_base_reg    <= in_data.color_a;
            m_default_reg <= in_data.is_default;
        end
    end

    // The true channel result stays within 0..255, so adding modulo 256 is exact.
    always_comb
    begin
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            o_color_next[c*CHAN_BITS +: CHAN_BITS] = m_base_reg[c*CHAN_BITS +: CHAN_BITS]
                + m_prod_reg[c][FRAC_BITS +: CHAN_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && m_valid_reg)
        begin
            o_color_reg   <= o_color_next;
            o_default_reg <= m_default_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign red        = o_color_reg[2*CHAN_BITS +: CHAN_BITS];
    assign green      = o_color_reg[CHAN_BITS +: CHAN_BITS];
    assign blue       = o_color_reg[0 +: CHAN_BITS];
    assign is_default = o_default_reg;

endmodule

FILE: design/scalar_to_rgb_color_map_unit.sv
// Stages: stop compare, interval select, a 4-stage divider that resolves 4 quotient
// bits per stage, then a multiply and an add stage before the color output.
// Throughput: one sample per cycle unless output stalls have filled every stage.
// Every stage holds its own valid bit, so bubbles fill in while the output stalls.
// Reset clears all valid bits and loads the default five-stop map in continuous mode.
module scalar_to_rgb_color_map_unit
    import scm_pkg::*;
#(
    parameter int MAX_STOPS   = 6,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    scm_sample_if.sink                samples,
    scm_color_if.source               colors,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    stop_t                 stop_reg [MAX_STOPS];
    logic [COUNT_BITS-1:0] stops_used_reg;
    logic                  continuous_reg;

    logic                  pipe_valid [DIV_STAGES+1];
    logic                  pipe_ready [DIV_STAGES+1];
    div_t                  pipe_data  [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STOPS; i++)
            begin
                stop_reg[i] <= STOP_RESET[i];
            end
            stops_used_reg <= STOPS_USED_RESET;
            continuous_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < MAX_STOPS; i++)
            begin
                if (cfg_index == REG_STOP0 + CFG_INDEX_BITS'(i))
                begin
                    stop_reg[i] <= cfg_data;
                end
            end
            case (cfg_index)
                REG_STOPS_USED: stops_used_reg <= cfg_data[COUNT_BITS-1:0];
                REG_CONTINUOUS: continuous_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    scm_stop_select #(
        .MAX_STOPS   (MAX_STOPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (samples.valid),
        .in_ready   (samples.ready),
        .sample     (samples.sample),
        .stops      (stop_reg),
        .stops_used (stops_used_reg),
        .continuous (continuous_reg),
        .out_valid  (pipe_valid[0]),
        .out_ready  (pipe_ready[0]),
        .out_data   (pipe_data[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        scm_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[s]),
            .in_ready  (pipe_ready[s]),
            .in_data   (pipe_data[s]),
            .out_valid (pipe_valid[s+1]),
            .out_ready (pipe_ready[s+1]),
            .out_data  (pipe_data[s+1])
        );
    end

    scm_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pipe_valid[DIV_STAGES]),
        .in_ready   (pipe_ready[DIV_STAGES]),
        .in_data    (pipe_data[DIV_STAGES]),
        .out_valid  (colors.valid),
        .out_ready  (colors.ready),
        .red        (colors.red),
        .green      (colors.green),
        .blue       (colors.blue),
        .is_default (colors.is_default)
    );

`ifndef NO_ASSERTIONS
    // Input back-pressure only appears once every stage is full and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (colors.valid && !colors.ready))
        else $error("input stalled while the pipeline still has room");

    // The empty map always gives black.
    assert property (@(posedge clk) disable iff (!rst_n)
        (colors.valid && colors.is_default) |->
            (colors.red == 8'd0 && colors.green == 8'd0 && colors.blue == 8'd0))
        else $error("default result carries a nonzero color");

    // A transaction taken at the output with nothing behind it leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (colors.valid && colors.ready && !u_blend.m_valid_reg) |=> !colors.valid)
        else $error("output valid without a transaction behind it");
`endif

endmodule

FILE: tb/scalar_to_rgb_color_map_checker.sv
`timescale 1ns / 100ps

module scalar_to_rgb_color_map_checker
    import scm_pkg::*;
#(
    parameter int MAX_STOPS   = 6,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    input  logic                      sample_ready,
    input  logic [SAMPLE_BITS-1:0]    sample,
    input  logic                      color_valid,
    input  logic                      color_ready,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic                      is_default,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       is_default;
    } pixel_t;

    stop_t                 map_stops [NUM_STOP_REGS];
    logic [COUNT_BITS-1:0] map_count;
    logic                  map_continuous;
    pixel_t                expected_pixels [$];
    pixel_t                want;
    int                    fail_total;

    function automatic pixel_t map_color(input logic [SAMPLE_BITS-1:0] level);
        pixel_t                px;
        int unsigned           n;
        int unsigned           k;
        int unsigned           x;
        int unsigned           lo;
        int unsigned           span;
        int unsigned           frac;
        logic [COLOR_BITS-1:0] ca;
        logic [COLOR_BITS-1:0] cb;
        logic [COLOR_BITS-1:0] c;
        px = '0;
        x = 32'(level);
        n = (map_count > MAX_STOPS) ? MAX_STOPS : map_count;
        if (n == 0)
        begin
            px.is_default = 1'b1;
            return px;
        end
        if (x < map_stops[0].value)
        begin
            c = map_stops[0].color;
        end
        else if (x >= map_stops[n-1].value)
        begin
            c = map_stops[n-1].color;
        end
        else
        begin
            // The first stop above the sample bounds the interval, so the span
            // is never zero even when the stops are out of order.
            k = 1;
            while (k < n - 1 && x >= map_stops[k].value)
                k++;
            ca = map_stops[k-1].color;
            cb = map_stops[k].color;
            if (map_continuous)
            begin
                lo = 32'(map_stops[k-1].value);
                span = map_stops[k].value - lo;
                frac = ((x - lo) << FRAC_BITS) / span;
                for (int ch = 0; ch < NUM_CHANS; ch++)
                    c[ch*8 +: 8] = 8'((ca[ch*8 +: 8] * (32'd65536 - frac)
                                       + cb[ch*8 +: 8] * frac) >> FRAC_BITS);
            end
            else
            begin
                c = ca;
            end
        end
        {px.red, px.green, px.blue} = c;
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_stops = STOP_RESET;
            map_count = STOPS_USED_RESET;
            map_continuous = 1'b1;
            expected_pixels.delete();
            fail_total = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (color_valid && color_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("color transaction arrived with no sample outstanding");
                    fail_total++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (red !== want.red)
                    begin
                        $error("red: expected %0d, actual %0d", want.red, red);
                        fail_total++;
                    end
                    if (green !== want.green)
                    begin
                        $error("green: expected %0d, actual %0d", want.green, green);
                        fail_total++;
                    end
                    if (blue !== want.blue)
                    begin
                        $error("blue: expected %0d, actual %0d", want.blue, blue);
                        fail_total++;
                    end
                    if (is_default !== want.is_default)
                    begin
                        $error("is_default: expected %0d, actual %0d", want.is_default,
                               is_default);
                        fail_total++;
                    end
                end
            end
            // Predict with the map as it stood before any write at this edge.
            if (sample_valid && sample_ready)
                expected_pixels = {expected_pixels, map_color(sample)};
            if (cfg_wr_en)
            begin
                if (cfg_index < REG_STOPS_USED)
                    map_stops[cfg_index - REG_STOP0] = cfg_data;
                else if (cfg_index == REG_STOPS_USED)
                    map_count = cfg_data[COUNT_BITS-1:0];
                else if (cfg_index == REG_CONTINUOUS)
                    map_continuous = cfg_data[0];
            end
            mismatches <= fail_total;
            outstanding <= expected_pixels.size();
        end
    end

endmodule

FILE: tb/scalar_to_rgb_color_map_unit_test.sv
`timescale 1ns / 100ps

module scalar_to_rgb_color_map_unit_test;

    import scm_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_STOPS     = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 100;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        mismatches;
    int                        outstanding;
    int unsigned               cycle_count = 0;
    int unsigned               gap_odds = 0;
    int unsigned               stall_odds = 0;
    int unsigned               stall_left = 0;

    scm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    scm_color_if color_ch ();

    scalar_to_rgb_color_map_unit #(
        .MAX_STOPS   (MAX_STOPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .colors    (color_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scalar_to_rgb_color_map_checker #(
        .MAX_STOPS   (MAX_STOPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) color_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_ch.valid),
        .sample_ready (sample_ch.ready),
        .sample       (sample_ch.sample),
        .color_valid  (color_ch.valid),
        .color_ready  (color_ch.ready),
        .red          (color_ch.red),
        .green        (color_ch.green),
        .blue         (color_ch.blue),
        .is_default   (color_ch.is_default),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            color_ch.ready <= 1'b1;
        end
        else if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            color_ch.ready <= 1'b1;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            stall_left <= $urandom_range(1, 17);
            color_ch.ready <= 1'b0;
        end
    end

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            2: return 8;
            default: return 25;
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] level);
        int unsigned gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 17);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= level;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Lets every outstanding color come out, then waits out the pipeline.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_map(input stop_t stops [NUM_STOP_REGS],
                               input logic [COUNT_BITS-1:0] used, input logic smooth);
        settle();
        for (int i = 0; i < NUM_STOP_REGS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_STOP0 + CFG_INDEX_BITS'(i);
            cfg_data <= stops[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_STOPS_USED;
        cfg_data <= CFG_DATA_BITS'(used);
        @(posedge clk);
        cfg_index <= REG_CONTINUOUS;
        cfg_data <= CFG_DATA_BITS'(smooth);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        stop_t                 map [NUM_STOP_REGS];
        logic [15:0]           vals [$];
        logic [COLOR_BITS-1:0] hue;
        logic [COUNT_BITS-1:0] used;
        logic                  smooth;
        logic [15:0]           level;
        int unsigned           shape;
        int unsigned           pick;

        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_STOP0;
        cfg_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.sample <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds = 4;
        stall_odds = 4;

        // Map as it comes out of reset: both ends, stop boundaries, toggled bits.
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h4000);
        send_sample(16'h3FFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);

        // Empty map gives the default black.
        map = STOP_RESET;
        program_map(map, 3'd0, 1'b1);
        send_sample(16'h1234);
        send_sample(16'hFFFF);

        // Out-of-order stops, extreme colors, and a count above the stop limit.
        map = '{40'h0000000000, 40'h0001FFFFFF, 40'h100000FF00,
                40'h0800123456, 40'h8000FF00FF, 40'hFFFFFFFFFF};
        program_map(map, 3'd7, 1'b1);
        send_sample(16'h0000);
        send_sample(16'h0900);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);

        // Same stops in banded mode.
        program_map(map, 3'd7, 1'b0);
        send_sample(16'h0001);
        send_sample(16'h4000);
        send_sample(16'hFFFE);

        // A single stop colors everything alike.
        map[0] = {16'h8000, 24'h00A5A5};
        program_map(map, 3'd1, 1'b1);
        send_sample(16'h0000);
        send_sample(16'hFFFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            vals.delete();
            for (int i = 0; i < NUM_STOP_REGS; i++)
                vals = {vals, 16'($urandom_range(0, 65535))};
            // Mostly sorted maps; some with repeated values, some packed into a
            // narrow range, and a few left unsorted.
            shape = $urandom_range(0, 9);
            if (shape != 0)
                vals.sort();
            if (shape == 1)
            begin
                for (int i = 1; i < NUM_STOP_REGS; i++)
                    if ($urandom_range(0, 1) == 1)
                        vals[i] = vals[i-1];
            end
            else if (shape == 2)
            begin
                for (int i = 0; i < NUM_STOP_REGS; i++)
                    vals[i] = vals[i] >> 10;
            end
            for (int i = 0; i < NUM_STOP_REGS; i++)
            begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    hue = '0;
                else if (pick == 1)
                    hue = '1;
                else
                    hue = COLOR_BITS'($urandom());
                map[i] = {vals[i], hue};
            end
            pick = $urandom_range(0, 15);
            if (pick == 0)
                used = 3'd0;
            else if (pick == 1)
                used = 3'd7;
            else if (pick == 2)
                used = 3'd1;
            else
                used = COUNT_BITS'($urandom_range(2, 6));
            smooth = ($urandom_range(0, 3) != 0);
            if (phase >= RANDOM_PHASES - 2)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            program_map(map, used, smooth);
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                if (phase < RANDOM_PHASES - 2 && item % 32 == 0)
                begin
                    gap_odds = pick_odds();
                    stall_odds = pick_odds();
                end
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    level = ($urandom_range(0, 1) == 1 ? 16'hFFFF : 16'h0000)
                            ^ 16'($urandom_range(0, 1));
                else if (pick < 10)
                    level = map[$urandom_range(0, NUM_STOP_REGS - 1)].value
                            + 16'($urandom_range(0, 4)) - 16'd2;
                else
                    level = 16'($urandom());
                send_sample(level);
            end
        end

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
